// File: rtl/fractional_divider_param_calc_defines.svh
// Assertion macros used by the checker file.
`ifndef FRACTIONAL_DIVIDER_PARAM_CALC_DEFINES_SVH
`define FRACTIONAL_DIVIDER_PARAM_CALC_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define FDPC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define FDPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/fdpc_pkg.sv
package fdpc_pkg;

   localparam int FREQ_BITS = 32;
   localparam int ALU_BITS  = FREQ_BITS + 1;
   localparam int FRAC_BITS = 7;
   localparam int P1_BITS   = 18;
   localparam int CNT_BITS  = $clog2(FREQ_BITS);
   localparam int WIDE_BITS = FREQ_BITS + FRAC_BITS;

   localparam logic [WIDE_BITS-1:0] P1_OFFSET = WIDE_BITS'(512);
   localparam logic [WIDE_BITS-1:0] P1_MAX    = WIDE_BITS'(262143);
   localparam logic [CNT_BITS-1:0]  DIV_LAST  = CNT_BITS'(FREQ_BITS - 1);
   localparam logic [CNT_BITS-1:0]  FRAC_LAST = CNT_BITS'(FRAC_BITS - 1);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_DIVIDE  = 9'b000000010,
      ST_GAPS    = 9'b000000100,
      ST_WALK    = 9'b000001000,
      ST_PROD_LO = 9'b000010000,
      ST_PROD_HI = 9'b000100000,
      ST_PICK    = 9'b001000000,
      ST_FRAC    = 9'b010000000,
      ST_DONE    = 9'b100000000
   } fdpc_state_type;

   typedef struct packed {
      logic [ALU_BITS-1:0] lhs;
      logic [ALU_BITS-1:0] rhs;
   } fdpc_alu_op_type;

   typedef struct packed {
      logic [ALU_BITS-1:0] mag;
      logic                lt;
   } fdpc_alu_res_type;

   typedef struct packed {
      logic idle;
      logic done;
   } fdpc_status_type;

endpackage

// File: rtl/fdpc_req_if.sv
interface fdpc_req_if;
   logic                           valid;
   logic                           ready;
   logic [fdpc_pkg::FREQ_BITS-1:0] dividend_freq;
   logic [fdpc_pkg::FREQ_BITS-1:0] divisor_freq;

   modport source (output valid, output dividend_freq, output divisor_freq, input ready);
   modport sink   (input valid, input dividend_freq, input divisor_freq, output ready);
endinterface

// File: rtl/fdpc_rsp_if.sv
interface fdpc_rsp_if #(parameter int DEN_BITS = 20);
   logic                         valid;
   logic                         ready;
   logic [fdpc_pkg::P1_BITS-1:0] p1_word;
   logic [DEN_BITS-1:0]          p2_word;
   logic [DEN_BITS-1:0]          p3_word;
   logic                         valid_res;

   modport source (output valid, output p1_word, output p2_word, output p3_word,
                   output valid_res, input ready);
   modport sink   (input valid, input p1_word, input p2_word, input p3_word,
                   input valid_res, output ready);
endinterface

// File: rtl/fdpc_csr_if.sv
interface fdpc_csr_if #(parameter int DEN_BITS = 20);
   logic                valid;
   logic                ready;
   logic [DEN_BITS-1:0] den_limit;

   modport source (output valid, output den_limit, input ready);
   modport sink   (input valid, input den_limit, output ready);
endinterface

// File: rtl/fdpc_alu.sv
module fdpc_alu (
   input  fdpc_pkg::fdpc_alu_op_type  op,
   output fdpc_pkg::fdpc_alu_res_type res
);

   logic lt;

   assign lt      = op.lhs < op.rhs;
   assign res.lt  = lt;
   assign res.mag = lt ? (op.rhs - op.lhs) : (op.lhs - op.rhs);

endmodule

// File: rtl/fdpc_mul.sv
module fdpc_mul #(
   parameter int A_BITS = 32,
   parameter int B_BITS = 20
) (
   input  logic                       clock,
   input  logic [A_BITS-1:0]          mul_a,
   input  logic [B_BITS-1:0]          mul_b,
   output logic [A_BITS+B_BITS-1:0]   prod
);

   logic [A_BITS+B_BITS-1:0] prod_ff;
   logic [A_BITS+B_BITS-1:0] prod_in;

   assign prod_in = (A_BITS+B_BITS)'(mul_a) * (A_BITS+B_BITS)'(mul_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// File: rtl/fdpc_core.sv
module fdpc_core #(
   parameter int DEN_BITS = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [fdpc_pkg::FREQ_BITS-1:0] dividend_freq,
   input  logic [fdpc_pkg::FREQ_BITS-1:0] divisor_freq,
   input  logic [DEN_BITS-1:0]            den_limit,
   input  logic                           take,
   output fdpc_pkg::fdpc_status_type      status,
   output logic [fdpc_pkg::P1_BITS-1:0]   p1_word,
   output logic [DEN_BITS-1:0]            p2_word,
   output logic [DEN_BITS-1:0]            p3_word,
   output logic                           valid_res
);

   localparam int FB = fdpc_pkg::FREQ_BITS;
   localparam int AB = fdpc_pkg::ALU_BITS;
   localparam int WB = fdpc_pkg::WIDE_BITS;
   localparam logic [DEN_BITS-1:0] DEN_ONE = DEN_BITS'(1);

   fdpc_pkg::fdpc_state_type state_ff, state_in;
   logic [fdpc_pkg::CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                           zero_ff, zero_in;
   logic                           whole_ff, whole_in;
   logic [FB-1:0]                  quo_ff, quo_in;
   logic [FB-1:0]                  acc_ff, acc_in;
   logic [FB-1:0]                  div_ff, div_in;
   logic [FB-1:0]                  lo_ff, lo_in;
   logic [FB-1:0]                  hi_ff, hi_in;
   logic [DEN_BITS-1:0]            lower_num_ff, lower_num_in;
   logic [DEN_BITS-1:0]            lower_den_ff, lower_den_in;
   logic [DEN_BITS-1:0]            upper_num_ff, upper_num_in;
   logic [DEN_BITS-1:0]            upper_den_ff, upper_den_in;
   logic [DEN_BITS-1:0]            num_ff, num_in;
   logic [DEN_BITS-1:0]            den_ff, den_in;
   logic [DEN_BITS-1:0]            rem_ff, rem_in;
   logic [fdpc_pkg::FRAC_BITS-1:0] frac_ff, frac_in;
   logic [FB+DEN_BITS-1:0]         prod_ff, prod_in;

   fdpc_pkg::fdpc_alu_op_type      alu_op;
   fdpc_pkg::fdpc_alu_res_type     alu_res;
   logic [FB-1:0]                  mul_a;
   logic [DEN_BITS-1:0]            mul_b;
   logic [FB+DEN_BITS-1:0]         mul_prod;

   logic [FB:0]                    div_trial;
   logic [DEN_BITS:0]              frac_trial;
   logic [DEN_BITS:0]              med_num;
   logic [DEN_BITS:0]              med_den;
   logic                           walk_end;
   logic                           no_walk;
   logic                           pick_lower;
   logic [WB-1:0]                  wide;
   logic [WB-1:0]                  wide_off;
   logic                           in_range;

   fdpc_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   fdpc_mul #(.A_BITS(FB), .B_BITS(DEN_BITS)) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (mul_prod)
   );

   assign div_trial  = {acc_ff, quo_ff[FB-1]};
   assign frac_trial = {rem_ff, 1'b0};
   assign med_num    = {1'b0, lower_num_ff} + {1'b0, upper_num_ff};
   assign med_den    = {1'b0, lower_den_ff} + {1'b0, upper_den_ff};
   assign walk_end   = med_den > {1'b0, den_limit};
   assign no_walk    = (acc_ff == '0) || (den_limit[DEN_BITS-1:1] == '0);
   assign pick_lower = prod_ff < mul_prod;

   // L*d first, then H*b
   assign mul_a = (state_ff == fdpc_pkg::ST_PROD_HI) ? hi_ff : lo_ff;
   assign mul_b = (state_ff == fdpc_pkg::ST_PROD_HI) ? lower_den_ff : upper_den_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      zero_in      = zero_ff;
      whole_in     = whole_ff;
      quo_in       = quo_ff;
      acc_in       = acc_ff;
      div_in       = div_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lower_num_in = lower_num_ff;
      lower_den_in = lower_den_ff;
      upper_num_in = upper_num_ff;
      upper_den_in = upper_den_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      frac_in      = frac_ff;
      prod_in      = prod_ff;
      alu_op       = '0;
      unique case (state_ff)
         fdpc_pkg::ST_IDLE: begin
            if (start) begin
               quo_in       = dividend_freq;
               div_in       = divisor_freq;
               acc_in       = '0;
               cnt_in       = '0;
               zero_in      = (divisor_freq == '0);
               if (divisor_freq != '0) begin
                  lower_num_in = '0;
                  lower_den_in = DEN_ONE;
                  upper_num_in = DEN_ONE;
                  upper_den_in = DEN_ONE;
               end
               state_in     = (divisor_freq == '0) ? fdpc_pkg::ST_DONE : fdpc_pkg::ST_DIVIDE;
            end
         end
         fdpc_pkg::ST_DIVIDE: begin
            alu_op.lhs = div_trial;
            alu_op.rhs = {1'b0, div_ff};
            acc_in     = alu_res.lt ? div_trial[FB-1:0] : alu_res.mag[FB-1:0];
            quo_in     = {quo_ff[FB-2:0], ~alu_res.lt};
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == fdpc_pkg::DIV_LAST) begin
               state_in = fdpc_pkg::ST_GAPS;
            end
         end
         fdpc_pkg::ST_GAPS: begin
            alu_op.lhs = {1'b0, div_ff};
            alu_op.rhs = {1'b0, acc_ff};
            if (no_walk) begin
               num_in   = '0;
               den_in   = DEN_ONE;
               rem_in   = '0;
               whole_in = 1'b0;
               cnt_in   = '0;
               state_in = fdpc_pkg::ST_FRAC;
            end else begin
               lo_in    = acc_ff;
               hi_in    = alu_res.mag[FB-1:0];
               state_in = fdpc_pkg::ST_WALK;
            end
         end
         fdpc_pkg::ST_WALK: begin
            alu_op.lhs = {1'b0, lo_ff};
            alu_op.rhs = {1'b0, hi_ff};
            if (walk_end) begin
               state_in = fdpc_pkg::ST_PROD_LO;
            end else if (alu_res.lt) begin
               upper_num_in = med_num[DEN_BITS-1:0];
               upper_den_in = med_den[DEN_BITS-1:0];
               hi_in        = alu_res.mag[FB-1:0];
            end else begin
               lower_num_in = med_num[DEN_BITS-1:0];
               lower_den_in = med_den[DEN_BITS-1:0];
               lo_in        = alu_res.mag[FB-1:0];
            end
         end
         fdpc_pkg::ST_PROD_LO: begin
            state_in = fdpc_pkg::ST_PROD_HI;
         end
         fdpc_pkg::ST_PROD_HI: begin
            prod_in  = mul_prod;
            state_in = fdpc_pkg::ST_PICK;
         end
         fdpc_pkg::ST_PICK: begin
            // 1/1 chosen: the fraction carries into the integer part
            whole_in = ~pick_lower & (upper_num_ff == upper_den_ff);
            // tie goes to the upper bound
            if (pick_lower) begin
               num_in = lower_num_ff;
               den_in = lower_den_ff;
               rem_in = lower_num_ff;
            end else begin
               num_in = upper_num_ff;
               den_in = upper_den_ff;
               rem_in = whole_in ? '0 : upper_num_ff;
            end
            cnt_in   = '0;
            state_in = fdpc_pkg::ST_FRAC;
         end
         fdpc_pkg::ST_FRAC: begin
            alu_op.lhs = {{(AB-DEN_BITS-1){1'b0}}, frac_trial};
            alu_op.rhs = {{(AB-DEN_BITS){1'b0}}, den_ff};
            rem_in     = alu_res.lt ? frac_trial[DEN_BITS-1:0] : alu_res.mag[DEN_BITS-1:0];
            frac_in    = {frac_ff[fdpc_pkg::FRAC_BITS-2:0], ~alu_res.lt};
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == fdpc_pkg::FRAC_LAST) begin
               state_in = fdpc_pkg::ST_DONE;
            end
         end
         fdpc_pkg::ST_DONE: begin
            if (take) begin
               state_in = fdpc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fdpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdpc_pkg::ST_IDLE;
         lower_num_ff <= '0;
         lower_den_ff <= DEN_ONE;
         upper_num_ff <= DEN_ONE;
         upper_den_ff <= DEN_ONE;
      end else begin
         state_ff     <= state_in;
         lower_num_ff <= lower_num_in;
         lower_den_ff <= lower_den_in;
         upper_num_ff <= upper_num_in;
         upper_den_ff <= upper_den_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      zero_ff  <= zero_in;
      whole_ff <= whole_in;
      quo_ff   <= quo_in;
      acc_ff   <= acc_in;
      div_ff   <= div_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      frac_ff  <= frac_in;
      prod_ff  <= prod_in;
   end

   assign wide     = {quo_ff, frac_ff} +
                     {{(WB-fdpc_pkg::FRAC_BITS-1){1'b0}}, whole_ff,
                      {fdpc_pkg::FRAC_BITS{1'b0}}};
   assign wide_off = wide - fdpc_pkg::P1_OFFSET;
   assign in_range = (wide >= fdpc_pkg::P1_OFFSET) && (wide_off <= fdpc_pkg::P1_MAX);

   assign valid_res   = ~zero_ff & in_range;
   assign p1_word     = valid_res ? wide_off[fdpc_pkg::P1_BITS-1:0] : '0;
   assign p2_word     = valid_res ? rem_ff : '0;
   assign p3_word     = valid_res ? den_ff : '0;
   assign status.idle = (state_ff == fdpc_pkg::ST_IDLE);
   assign status.done = (state_ff == fdpc_pkg::ST_DONE);

endmodule

// File: rtl/fractional_divider_param_calc.sv
// One request at a time; a new one is taken once the previous result has moved to the
//   output register. The mediant walk runs one mediant per cycle through the shared
//   subtract/compare unit, which also runs the 32-step quotient and 7-step fraction
//   divide; the walk takes at most the denominator limit - 1 mediant steps and is skipped
//   with a zero fraction or a limit below 2, and a zero divisor skips the divide as well.
//   Reset (synchronous, active high): idle, no result pending, denominator limit all
//   ones.
module fractional_divider_param_calc #(
   parameter int DEN_BITS = 20
) (
   input  logic              clock,
   input  logic              reset,
   fdpc_req_if.sink          req_chan,
   fdpc_rsp_if.source        rsp_chan,
   fdpc_csr_if.sink          csr_chan
);

   logic [DEN_BITS-1:0]          max_den_ff, max_den_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fdpc_pkg::P1_BITS-1:0] p1_ff;
   logic [DEN_BITS-1:0]          p2_ff;
   logic [DEN_BITS-1:0]          p3_ff;
   logic                         valid_res_ff;

   fdpc_pkg::fdpc_status_type    status;
   logic                         start;
   logic                         load;
   logic [fdpc_pkg::P1_BITS-1:0] core_p1;
   logic [DEN_BITS-1:0]          core_p2;
   logic [DEN_BITS-1:0]          core_p3;
   logic                         core_valid_res;

   assign start = req_chan.valid & status.idle;
   assign load  = status.done & (~rsp_valid_ff | rsp_chan.ready);

   fdpc_core #(.DEN_BITS(DEN_BITS)) u_core (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .dividend_freq   (req_chan.dividend_freq),
      .divisor_freq    (req_chan.divisor_freq),
      .den_limit       (max_den_ff),
      .take            (load),
      .status          (status),
      .p1_word         (core_p1),
      .p2_word         (core_p2),
      .p3_word         (core_p3),
      .valid_res       (core_valid_res)
   );

   assign max_den_in   = csr_chan.valid ? csr_chan.den_limit : max_den_ff;
   assign rsp_valid_in = load | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_den_ff   <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_den_ff   <= max_den_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         p1_ff        <= core_p1;
         p2_ff        <= core_p2;
         p3_ff        <= core_p3;
         valid_res_ff <= core_valid_res;
      end
   end

   assign req_chan.ready     = status.idle;
   assign csr_chan.ready     = 1'b1;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.p1_word   = p1_ff;
   assign rsp_chan.p2_word   = p2_ff;
   assign rsp_chan.p3_word   = p3_ff;
   assign rsp_chan.valid_res = valid_res_ff;

endmodule

// File: rtl/fdpc_checker.sv
`include "fractional_divider_param_calc_defines.svh"

module fdpc_checker #(
   parameter int DEN_BITS = 20
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [fdpc_pkg::P1_BITS-1:0] rsp_p1_word,
   input logic [DEN_BITS-1:0]          rsp_p2_word,
   input logic [DEN_BITS-1:0]          rsp_p3_word,
   input logic                         rsp_valid_res
);

   `FDPC_ASSERT_NEXT(a_busy_after_request, req_valid && req_ready, !req_ready, "ready after request")
   `FDPC_ASSERT_NOW(a_invalid_words_zero, rsp_valid && !rsp_valid_res, (rsp_p1_word == '0) && (rsp_p2_word == '0) && (rsp_p3_word == '0), "invalid result with nonzero words")
   `FDPC_ASSERT_NOW(a_p2_below_p3, rsp_valid && rsp_valid_res, (rsp_p3_word != '0) && (rsp_p2_word < rsp_p3_word), "p2 not below p3")
   `FDPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_p1_word) && $stable(rsp_p2_word) && $stable(rsp_p3_word) && $stable(rsp_valid_res), "stalled result changed")

endmodule

bind fractional_divider_param_calc fdpc_checker #(.DEN_BITS(DEN_BITS)) u_fdpc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_p1_word   (rsp_chan.p1_word),
   .rsp_p2_word   (rsp_chan.p2_word),
   .rsp_p3_word   (rsp_chan.p3_word),
   .rsp_valid_res (rsp_chan.valid_res)
);

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int DEN_BITS = 20;
   localparam logic [DEN_BITS-1:0] DEN_ALL = '1;
   localparam longint unsigned P1_BIAS = 512;
   localparam longint unsigned P1_TOP = 262143;
   localparam longint unsigned STEP_BUDGET = 3000;
   localparam int HOLD_CYCLES = 8000;
   localparam int SETTLE_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 5000000;
   localparam int PLAN_ROWS = 22;
   localparam int PHASE_ITEMS = 20;

   typedef struct packed {
      logic [fdpc_pkg::P1_BITS-1:0] p1_word;
      logic [DEN_BITS-1:0]          p2_word;
      logic [DEN_BITS-1:0]          p3_word;
      logic                         valid_res;
   } divider_words_type;

   typedef struct packed {
      logic [DEN_BITS-1:0]            max_den;
      logic [fdpc_pkg::FREQ_BITS-1:0] dividend;
      logic [fdpc_pkg::FREQ_BITS-1:0] divisor;
      logic                           known;
      divider_words_type              words;
   } plan_row_type;

   logic clock;
   logic reset;

   fdpc_req_if                      req_if ();
   fdpc_rsp_if #(.DEN_BITS(DEN_BITS)) rsp_if ();
   fdpc_csr_if #(.DEN_BITS(DEN_BITS)) csr_if ();

   fractional_divider_param_calc #(.DEN_BITS(DEN_BITS)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   divider_words_type pending_words[$];
   logic [DEN_BITS-1:0] max_den = DEN_ALL;
   int failures = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   bit long_hold = 1'b0;

   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{DEN_ALL, 32'h0000_0000, 32'h0000_0000, 1'b1, '0},
      '{DEN_ALL, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '0},
      '{DEN_ALL, 32'h0000_0000, 32'h0000_0001, 1'b1, '0},
      '{DEN_ALL, 32'd4, 32'd1, 1'b1, '{18'd0, 20'd0, 20'd1, 1'b1}},
      '{DEN_ALL, 32'd2051, 32'd1, 1'b1, '{18'd262016, 20'd0, 20'd1, 1'b1}},
      '{DEN_ALL, 32'd2052, 32'd1, 1'b1, '0},
      '{DEN_ALL, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '0},
      '{DEN_ALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0},
      '{DEN_ALL, 32'h9E37_79B9, 32'h0040_0000, 1'b0, '0},
      '{DEN_ALL, 32'h1234_5678, 32'h0010_0003, 1'b0, '0},
      '{20'd0, 32'd9, 32'd2, 1'b1, '{18'd0, 20'd0, 20'd1, 1'b1}},
      '{20'd0, 32'd2561, 32'd5, 1'b1, '{18'd65024, 20'd0, 20'd1, 1'b1}},
      '{20'd1, 32'd9, 32'd2, 1'b1, '{18'd0, 20'd0, 20'd1, 1'b1}},
      '{20'd2, 32'd9, 32'd2, 1'b1, '{18'd64, 20'd0, 20'd2, 1'b1}},
      // equidistant from both bounds, upper wins
      '{20'd2, 32'd17, 32'd4, 1'b1, '{18'd64, 20'd0, 20'd2, 1'b1}},
      '{20'd4095, 32'd9, 32'd2, 1'b0, '0},
      '{20'd4095, 32'hFFFF_FFFF, 32'h3FFF_FFFF, 1'b0, '0},
      '{20'd4095, 32'hFFFF_FFFF, 32'h0080_0000, 1'b0, '0},
      '{20'd4095, 32'h8000_0000, 32'h00C0_0001, 1'b0, '0},
      '{DEN_ALL, 32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b0, '0},
      '{DEN_ALL, 32'hFFFF_FFFF, 32'h0001_F001, 1'b0, '0},
      '{DEN_ALL, 32'h5555_5555, 32'h00AB_CDEF, 1'b0, '0}
   };

   // Exact mediant walk; steps counts single mediant moves, which sets the block's latency.
   function automatic divider_words_type divider_words(
         input logic [fdpc_pkg::FREQ_BITS-1:0] dividend,
         input logic [fdpc_pkg::FREQ_BITS-1:0] divisor, input logic [DEN_BITS-1:0] limit,
         output longint unsigned steps);
      longint unsigned q, r, f, m, a, b, c, d, lo_gap, hi_gap, k, num, den, frac, p1;
      divider_words_type w;
      w = '0;
      steps = 0;
      if (divisor == '0) begin
         return w;
      end
      f = 64'(divisor);
      q = 64'(dividend) / f;
      r = 64'(dividend) % f;
      m = 64'(limit);
      a = 0;
      b = 1;
      c = 1;
      d = 1;
      num = 0;
      den = 1;
      if (r != 0 && m > 1) begin
         while (b + d <= m) begin
            lo_gap = r * b - a * f;
            hi_gap = c * f - r * d;
            if (r * (b + d) < (a + c) * f) begin
               k = (m - d) / b;
               if (lo_gap != 0 && (hi_gap - 1) / lo_gap < k) begin
                  k = (hi_gap - 1) / lo_gap;
               end
               c = c + k * a;
               d = d + k * b;
            end else begin
               k = (m - b) / d;
               if (lo_gap / hi_gap < k) begin
                  k = lo_gap / hi_gap;
               end
               a = a + k * c;
               b = b + k * d;
            end
            steps = steps + k;
         end
         if ((r * b - a * f) * d < (c * f - r * d) * b) begin
            num = a;
            den = b;
         end else begin
            num = c;
            den = d;
         end
      end
      frac = (num << 7) / den;
      p1 = (q << 7) + frac;
      if (p1 < P1_BIAS || p1 - P1_BIAS > P1_TOP) begin
         return w;
      end
      w.p1_word = fdpc_pkg::P1_BITS'(p1 - P1_BIAS);
      w.p2_word = DEN_BITS'((num << 7) - den * frac);
      w.p3_word = DEN_BITS'(den);
      w.valid_res = 1'b1;
      return w;
   endfunction

   task automatic send_request(input logic [fdpc_pkg::FREQ_BITS-1:0] dividend,
         input logic [fdpc_pkg::FREQ_BITS-1:0] divisor, input divider_words_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.dividend_freq <= dividend;
      req_if.divisor_freq <= divisor;
      do @(posedge clock); while (!req_if.ready);
      pending_words.push_back(w);
   endtask

   task automatic set_den_limit(input logic [DEN_BITS-1:0] value);
      req_if.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.den_limit <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      max_den = value;
      burst_left = 0;
   endtask

   // Mostly in-range quotients with a random fraction; walks that run too long are redrawn.
   task automatic pick_request(output logic [fdpc_pkg::FREQ_BITS-1:0] dividend,
         output logic [fdpc_pkg::FREQ_BITS-1:0] divisor);
      longint unsigned q, dv, r, steps;
      int tries;
      steps = 0;
      dividend = '0;
      divisor = '0;
      for (tries = 0; tries < 50; tries++) begin
         case ($urandom_range(0, 9))
            0: begin
               dividend = $urandom;
               divisor = $urandom;
            end
            1: begin
               dividend = $urandom;
               divisor = ($urandom_range(0, 1) == 0) ? '0 :
                         fdpc_pkg::FREQ_BITS'($urandom_range(1, 8));
            end
            default: begin
               q = 64'($urandom_range(3, 2053));
               dv = 64'($urandom_range(1, 32'(64'hFFFF_FFFF / (q + 1))));
               r = ($urandom_range(0, 7) == 0) ? 0 : 64'($urandom_range(0, 32'(dv - 1)));
               dividend = fdpc_pkg::FREQ_BITS'(q * dv + r);
               divisor = fdpc_pkg::FREQ_BITS'(dv);
            end
         endcase
         void'(divider_words(dividend, divisor, max_den, steps));
         if (steps <= STEP_BUDGET) begin
            break;
         end
      end
      if (steps > STEP_BUDGET) begin
         divisor = '0;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned span;
      int unsigned mode;
      span = 0;
      mode = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            if (span == 0) begin
               span = $urandom_range(16, 96);
               mode = $urandom_range(0, 2);
            end
            span--;
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      divider_words_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_words.size() == 0) begin
            $error("result with no request outstanding");
            failures++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_if.p1_word !== want.p1_word) begin
               $error("p1_word: expected %0d, got %0d", want.p1_word, rsp_if.p1_word);
               failures++;
            end
            if (rsp_if.p2_word !== want.p2_word) begin
               $error("p2_word: expected %0d, got %0d", want.p2_word, rsp_if.p2_word);
               failures++;
            end
            if (rsp_if.p3_word !== want.p3_word) begin
               $error("p3_word: expected %0d, got %0d", want.p3_word, rsp_if.p3_word);
               failures++;
            end
            if (rsp_if.valid_res !== want.valid_res) begin
               $error("valid_res: expected %0d, got %0d", want.valid_res, rsp_if.valid_res);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      plan_row_type row;
      divider_words_type predicted;
      longint unsigned steps;
      logic [fdpc_pkg::FREQ_BITS-1:0] dividend;
      logic [fdpc_pkg::FREQ_BITS-1:0] divisor;
      logic [DEN_BITS-1:0] value;
      int i;
      int phase;
      int n;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.dividend_freq <= '0;
      req_if.divisor_freq <= '0;
      csr_if.valid <= 1'b0;
      csr_if.den_limit <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < PLAN_ROWS; i++) begin
         row = directed_plan[i];
         if (row.max_den != max_den) begin
            set_den_limit(row.max_den);
         end
         predicted = divider_words(row.dividend, row.divisor, max_den, steps);
         send_request(row.dividend, row.divisor, row.known ? row.words : predicted);
      end

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: value = DEN_BITS'($urandom_range(2, 32'(DEN_ALL)));
            1: value = DEN_ALL;
            2: value = DEN_BITS'(3);
            3: value = DEN_BITS'($urandom_range(2, 300));
            default: value = DEN_BITS'($urandom_range(0, 32'(DEN_ALL)));
         endcase
         set_den_limit(value);
         // output held off while requests keep coming
         if (phase == 1) begin
            long_hold = 1'b1;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick_request(dividend, divisor);
            predicted = divider_words(dividend, divisor, max_den, steps);
            send_request(dividend, divisor, predicted);
         end
      end

      req_if.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
